@@ rtl/core/gtfb_pkg.sv @@
// Package for the blended g-h tracking filter: widths, control word layout
// and the microprogram ROM that sequences the shared multiply/accumulate datapath.
// No dependencies.
`timescale 1ns / 1ps

package gtfb_pkg;

    localparam int MEAS_W     = 32;
    localparam int DT_W       = 24;
    localparam int POS_W      = 32;
    localparam int VEL_W      = 48;
    localparam int G_W        = 17;
    localparam int H_W        = 18;
    localparam int A_W        = 17;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_W      = 34;
    localparam int ACC_W      = 60;
    localparam int RES_W      = 33;
    localparam int DIV_W      = 51;
    localparam int DIV_CNT_W  = 6;
    localparam int STEP_W     = 5;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;

    localparam logic [G_W-1:0] G_RESET = G_W'(32768);
    localparam logic [H_W-1:0] H_RESET = H_W'(6554);
    localparam logic [A_W-1:0] A_RESET = A_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 2'd2;

    // Microprogram addresses.
    localparam logic [STEP_W-1:0] ST_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] ST_MUL_M1    = 5'd1;
    localparam logic [STEP_W-1:0] ST_MUL_M2    = 5'd2;
    localparam logic [STEP_W-1:0] ST_BLEND_ADD = 5'd3;
    localparam logic [STEP_W-1:0] ST_BLEND_RND = 5'd4;
    localparam logic [STEP_W-1:0] ST_BLEND_SAT = 5'd5;
    localparam logic [STEP_W-1:0] ST_INC_LO    = 5'd6;
    localparam logic [STEP_W-1:0] ST_INC_RND   = 5'd7;
    localparam logic [STEP_W-1:0] ST_INC_ADD   = 5'd8;
    localparam logic [STEP_W-1:0] ST_PRED_ADD  = 5'd9;
    localparam logic [STEP_W-1:0] ST_PRED_SAT  = 5'd10;
    localparam logic [STEP_W-1:0] ST_RES       = 5'd11;
    localparam logic [STEP_W-1:0] ST_MUL_G     = 5'd12;
    localparam logic [STEP_W-1:0] ST_CORR_LOAD = 5'd13;
    localparam logic [STEP_W-1:0] ST_CORR_RND  = 5'd14;
    localparam logic [STEP_W-1:0] ST_CORR_ADD  = 5'd15;
    localparam logic [STEP_W-1:0] ST_POS_SAT   = 5'd16;
    localparam logic [STEP_W-1:0] ST_DIV_LOAD  = 5'd17;
    localparam logic [STEP_W-1:0] ST_DIV       = 5'd18;
    localparam logic [STEP_W-1:0] ST_VEL_ADD   = 5'd19;
    localparam logic [STEP_W-1:0] ST_VEL_SAT   = 5'd20;
    localparam logic [STEP_W-1:0] ST_COMMIT    = 5'd21;

    typedef enum logic [2:0] {
        MA_ALPHA,
        MA_COMP,
        MA_DT,
        MA_G,
        MA_H
    } mul_a_t;

    typedef enum logic [2:0] {
        MB_M1,
        MB_M2,
        MB_VL,
        MB_VH,
        MB_RES
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ROUND,
        ACC_ADD_POS,
        ACC_ADD_PRED,
        ACC_VEL_Q
    } acc_op_t;

    typedef enum logic [2:0] {
        LT_NONE,
        LT_BLEND,
        LT_PRED,
        LT_RES,
        LT_POSNEW,
        LT_DIV_LOAD,
        LT_VEL,
        LT_COMMIT
    } latch_t;

    typedef enum logic [2:0] {
        FL_NEXT,
        FL_WAIT_IN,
        FL_SKIP_IF_ZERO,
        FL_DIV_LOOP,
        FL_COMMIT,
        FL_JUMP
    } flow_t;

    typedef struct packed {
        logic              mul_en;
        mul_a_t            mul_a;
        mul_b_t            mul_b;
        acc_op_t           acc_op;
        latch_t            latch;
        logic              div_step;
        flow_t             flow;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        mul_en:   1'b0,
        mul_a:    MA_ALPHA,
        mul_b:    MB_M1,
        acc_op:   ACC_HOLD,
        latch:    LT_NONE,
        div_step: 1'b0,
        flow:     FL_NEXT,
        target:   ST_IDLE
    };

    // The microprogram. A product issued in one step is in the product
    // register for the next step and stays there until the next multiply.
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = CW_NOP;
        unique case (step)
            ST_IDLE:      cw.flow = FL_WAIT_IN;
            ST_MUL_M1:
            begin
                cw.mul_en = 1'b1;
                cw.mul_a  = MA_ALPHA;
                cw.mul_b  = MB_M1;
            end
            ST_MUL_M2:
            begin
                cw.acc_op = ACC_LOAD;
                cw.mul_en = 1'b1;
                cw.mul_a  = MA_COMP;
                cw.mul_b  = MB_M2;
            end
            ST_BLEND_ADD: cw.acc_op = ACC_ADD;
            ST_BLEND_RND: cw.acc_op = ACC_ROUND;
            ST_BLEND_SAT:
            begin
                cw.latch  = LT_BLEND;
                cw.mul_en = 1'b1;
                cw.mul_a  = MA_DT;
                cw.mul_b  = MB_VL;
            end
            ST_INC_LO:
            begin
                cw.acc_op = ACC_LOAD;
                cw.mul_en = 1'b1;
                cw.mul_a  = MA_DT;
                cw.mul_b  = MB_VH;
            end
            ST_INC_RND:   cw.acc_op = ACC_ROUND;
            ST_INC_ADD:   cw.acc_op = ACC_ADD;
            ST_PRED_ADD:  cw.acc_op = ACC_ADD_POS;
            ST_PRED_SAT:  cw.latch = LT_PRED;
            ST_RES:       cw.latch = LT_RES;
            ST_MUL_G:
            begin
                cw.mul_en = 1'b1;
                cw.mul_a  = MA_G;
                cw.mul_b  = MB_RES;
            end
            ST_CORR_LOAD: cw.acc_op = ACC_LOAD;
            ST_CORR_RND:  cw.acc_op = ACC_ROUND;
            ST_CORR_ADD:  cw.acc_op = ACC_ADD_PRED;
            ST_POS_SAT:
            begin
                cw.latch  = LT_POSNEW;
                cw.mul_en = 1'b1;
                cw.mul_a  = MA_H;
                cw.mul_b  = MB_RES;
            end
            ST_DIV_LOAD:
            begin
                cw.latch  = LT_DIV_LOAD;
                cw.flow   = FL_SKIP_IF_ZERO;
                cw.target = ST_COMMIT;
            end
            ST_DIV:
            begin
                cw.div_step = 1'b1;
                cw.flow     = FL_DIV_LOOP;
            end
            ST_VEL_ADD:   cw.acc_op = ACC_VEL_Q;
            ST_VEL_SAT:   cw.latch = LT_VEL;
            ST_COMMIT:
            begin
                cw.latch  = LT_COMMIT;
                cw.flow   = FL_COMMIT;
                cw.target = ST_IDLE;
            end
            default:
            begin
                cw.flow   = FL_JUMP;
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

@@ rtl/core/gh_tracking_filter_blended.sv @@
// Blended g-h tracking filter, top level: microprogram sequencer, shared
// multiplier, accumulator, serial divider and the stream ports.
// Depends on gtfb_pkg.
`timescale 1ns / 1ps

//  Channel   Direction  Payload
//  s_axis    in         tdata: first_measurement, second_measurement, elapsed_micros
//  m_axis    out        tdata: position_estimate; tuser: zero_interval
//  cfg       in         index 0 position_gain, 1 velocity_gain, 2 blend_weight
//
// One item is worked on at a time. An item with a nonzero interval passes
// from acceptance to the commit of its result through one accept step, 17
// arithmetic steps, the one-bit-per-cycle velocity divider with its 51
// quotient bits and 3 closing steps; a zero interval skips the divider.
// The divider loop sets the rate. The input is ready again in the cycle
// after the commit, while the result may still wait in the output register.
// Reset sets the gains and blend weight to their defaults and the filter state to zero.
// A stalled output holds the sequencer at its commit step until the register
// is free.
module gh_tracking_filter_blended
    import gtfb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] first_measurement, [63:32] second_measurement, [87:64] elapsed_micros
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] position_estimate
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] zero_interval
    output logic                  m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration and filter state.
    logic [G_W-1:0]                 g_reg;
    logic [H_W-1:0]                 h_reg;
    logic [A_W-1:0]                 alpha_reg;
    logic signed [POS_W-1:0]        pos_state_reg;
    logic signed [VEL_W-1:0]        vel_state_reg;

    // Sequencer.
    logic [STEP_W-1:0]              step_reg;
    logic [STEP_W-1:0]              step_next;
    logic [DIV_CNT_W-1:0]           div_cnt_reg;
    ctrl_word_t                     cw;

    // Latched item and datapath registers.
    logic signed [MEAS_W-1:0]       m1_reg;
    logic signed [MEAS_W-1:0]       m2_reg;
    logic [DT_W-1:0]                dt_reg;
    logic                           zero_reg;
    logic signed [ACC_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [POS_W-1:0]        blend_reg;
    logic signed [POS_W-1:0]        pred_reg;
    logic signed [RES_W-1:0]        res_reg;
    logic signed [POS_W-1:0]        posnew_reg;
    logic [DIV_W-1:0]               quo_reg;
    logic [DT_W-1:0]                rem_reg;
    logic                           neg_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [OUT_DATA_W-1:0]          out_data_reg;
    logic                           out_zero_reg;

    logic                           in_fire;
    logic                           out_free;
    logic                           commit_en;
    logic signed [MUL_W-1:0]        mul_a_val;
    logic signed [MUL_W-1:0]        mul_b_val;
    logic signed [2*MUL_W-1:0]      mul_full;
    logic signed [ACC_W-1:0]        acc_rnd_sum;
    logic signed [ACC_W-1:0]        quo_signed;
    logic [ACC_W-1:0]               prod_mag;
    logic [DT_W:0]                  div_shift;
    logic [DT_W:0]                  div_diff;
    logic                           div_bit;

    localparam logic [MUL_W-1:0] ONE_Q16     = MUL_W'(65536);
    localparam logic [ACC_W-1:0] ROUND_HALF  = ACC_W'(32768);

    // Saturate the accumulator to a position word: in range when all bits
    // above the sign bit agree with it.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] x);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[ACC_W-1:POS_W-1];
        hi_zeros = ~|x[ACC_W-1:POS_W-1];
        if (hi_ones || hi_zeros)
            return x[POS_W-1:0];
        else if (x[ACC_W-1])
            return {1'b1, {(POS_W-1){1'b0}}};
        else
            return {1'b0, {(POS_W-1){1'b1}}};
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [ACC_W-1:0] x);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[ACC_W-1:VEL_W-1];
        hi_zeros = ~|x[ACC_W-1:VEL_W-1];
        if (hi_ones || hi_zeros)
            return x[VEL_W-1:0];
        else if (x[ACC_W-1])
            return {1'b1, {(VEL_W-1){1'b0}}};
        else
            return {1'b0, {(VEL_W-1){1'b1}}};
    endfunction

    assign cw            = ucode_rom(step_reg);
    assign s_axis_tready = (step_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign commit_en     = (cw.latch == LT_COMMIT) && out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

    // Shared multiplier operands. The second blend weight is one minus alpha,
    // which goes negative for alpha above one.
    always_comb
    begin
        unique case (cw.mul_a)
            MA_ALPHA: mul_a_val = signed'({{(MUL_W-A_W){1'b0}}, alpha_reg});
            MA_COMP:  mul_a_val = signed'(ONE_Q16 - {{(MUL_W-A_W){1'b0}}, alpha_reg});
            MA_DT:    mul_a_val = signed'({{(MUL_W-DT_W){1'b0}}, dt_reg});
            MA_G:     mul_a_val = signed'({{(MUL_W-G_W){1'b0}}, g_reg});
            MA_H:     mul_a_val = signed'({{(MUL_W-H_W){1'b0}}, h_reg});
            default:  mul_a_val = '0;
        endcase
    end

    // Velocity enters as a signed high part and an unsigned low 16 bits, so
    // that interval times velocity needs only two narrow products.
    always_comb
    begin
        unique case (cw.mul_b)
            MB_M1:   mul_b_val = {{(MUL_W-MEAS_W){m1_reg[MEAS_W-1]}}, m1_reg};
            MB_M2:   mul_b_val = {{(MUL_W-MEAS_W){m2_reg[MEAS_W-1]}}, m2_reg};
            MB_VL:   mul_b_val = signed'({{(MUL_W-16){1'b0}}, vel_state_reg[15:0]});
            MB_VH:   mul_b_val = {{(MUL_W-(VEL_W-16)){vel_state_reg[VEL_W-1]}},
                                  vel_state_reg[VEL_W-1:16]};
            MB_RES:  mul_b_val = {{(MUL_W-RES_W){res_reg[RES_W-1]}}, res_reg};
            default: mul_b_val = '0;
        endcase
    end

    assign mul_full    = mul_a_val * mul_b_val;
    assign acc_rnd_sum = acc_reg + signed'(ROUND_HALF);
    assign quo_signed  = neg_reg ? -signed'({{(ACC_W-DIV_W){1'b0}}, quo_reg})
                                 :  signed'({{(ACC_W-DIV_W){1'b0}}, quo_reg});
    assign prod_mag    = prod_reg[ACC_W-1] ? unsigned'(-prod_reg) : unsigned'(prod_reg);

    always_comb
    begin
        unique case (cw.acc_op)
            ACC_HOLD:     acc_next = acc_reg;
            ACC_LOAD:     acc_next = prod_reg;
            ACC_ADD:      acc_next = acc_reg + prod_reg;
            ACC_ROUND:    acc_next = acc_rnd_sum >>> 16;
            ACC_ADD_POS:  acc_next = acc_reg + ACC_W'(pos_state_reg);
            ACC_ADD_PRED: acc_next = acc_reg + ACC_W'(pred_reg);
            ACC_VEL_Q:    acc_next = ACC_W'(vel_state_reg) + quo_signed;
            default:      acc_next = acc_reg;
        endcase
    end

    // Restoring divider, one quotient bit per cycle. The remainder stays
    // below the interval, so it fits in the interval's width.
    assign div_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign div_diff  = div_shift - {1'b0, dt_reg};
    assign div_bit   = (div_shift >= {1'b0, dt_reg});

    always_comb
    begin
        unique case (cw.flow)
            FL_NEXT:         step_next = step_reg + 1'b1;
            FL_WAIT_IN:      step_next = in_fire ? step_reg + 1'b1 : step_reg;
            FL_SKIP_IF_ZERO: step_next = zero_reg ? cw.target : step_reg + 1'b1;
            FL_DIV_LOOP:     step_next = (div_cnt_reg == '0) ? step_reg + 1'b1 : step_reg;
            FL_COMMIT:       step_next = out_free ? cw.target : step_reg;
            FL_JUMP:         step_next = cw.target;
            default:         step_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            g_reg         <= G_RESET;
            h_reg         <= H_RESET;
            alpha_reg     <= A_RESET;
            pos_state_reg <= '0;
            vel_state_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;

            if (cw.latch == LT_DIV_LOAD)
                div_cnt_reg <= DIV_CNT_W'(DIV_W - 1);
            else if (cw.div_step && (div_cnt_reg != '0))
                div_cnt_reg <= div_cnt_reg - 1'b1;

            if (commit_en)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (commit_en)
                pos_state_reg <= posnew_reg;
            if (cw.latch == LT_VEL)
                vel_state_reg <= sat_vel(acc_reg);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POSITION_GAIN: g_reg     <= cfg_data[G_W-1:0];
                    REG_VELOCITY_GAIN: h_reg     <= cfg_data[H_W-1:0];
                    REG_BLEND_WEIGHT:  alpha_reg <= cfg_data[A_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            m1_reg   <= s_axis_tdata[MEAS_W-1:0];
            m2_reg   <= s_axis_tdata[2*MEAS_W-1:MEAS_W];
            dt_reg   <= s_axis_tdata[2*MEAS_W+DT_W-1:2*MEAS_W];
            zero_reg <= (s_axis_tdata[2*MEAS_W+DT_W-1:2*MEAS_W] == '0);
        end
        if (cw.mul_en)
            prod_reg <= mul_full[ACC_W-1:0];
        acc_reg <= acc_next;
        if (cw.latch == LT_BLEND)
            blend_reg <= sat_pos(acc_reg);
        if (cw.latch == LT_PRED)
            pred_reg <= sat_pos(acc_reg);
        if (cw.latch == LT_RES)
            res_reg <= RES_W'(blend_reg) - RES_W'(pred_reg);
        if (cw.latch == LT_POSNEW)
            posnew_reg <= sat_pos(acc_reg);
        if (cw.latch == LT_DIV_LOAD)
        begin
            quo_reg <= prod_mag[DIV_W-1:0];
            rem_reg <= '0;
            neg_reg <= prod_reg[ACC_W-1];
        end
        else if (cw.div_step)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], div_bit};
            rem_reg <= div_bit ? div_diff[DT_W-1:0] : div_shift[DT_W-1:0];
        end
        if (commit_en)
        begin
            out_data_reg <= posnew_reg;
            out_zero_reg <= zero_reg;
        end
    end

    // An accepted item always starts the program at its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> step_reg == ST_MUL_M1)
        else $error("sequencer did not start after an accepted item");

    // The divider never runs for a zero interval.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_DIV |-> !zero_reg)
        else $error("divider running on a zero interval");

    // The divider loop holds its step until the count runs out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_DIV && div_cnt_reg != '0) |=> step_reg == ST_DIV)
        else $error("divider loop left early");

    // A pending result is never overwritten: the commit step waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_COMMIT && out_valid_reg && !m_axis_tready)
            |=> step_reg == ST_COMMIT && $stable(out_data_reg))
        else $error("commit overran a pending result");

endmodule
